// ===== src/vnd_pkg.sv =====
// Shared widths and payload types for the vector normalize/direction pipeline.
package vnd_pkg;

  localparam int CW     = 32;
  localparam int FB     = 30;
  localparam int NC     = 3;
  localparam int MW     = CW + 1;
  localparam int QSW    = 2 * MW;
  localparam int SW     = QSW + 2;
  localparam int QW     = 2 * FB + 3;
  localparam int RW     = FB + 2;
  localparam int RMW    = RW + 2;
  localparam int OW     = FB + 2;
  localparam int DSTEPS = QW - 1;

  localparam logic OP_NORMALIZE = 1'b0;
  localparam logic OP_DIRECTION = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
  } vnd_in_t;

  typedef struct packed {
    logic signed [OW-1:0] unit_x;
    logic signed [OW-1:0] unit_y;
    logic signed [OW-1:0] unit_z;
    logic                 zero_vector;
  } vnd_out_t;

endpackage

// ===== src/vector3_normalize_direction.sv =====
// Top level: pipelined 3D vector normalizer and direction unit.
// Takes one transfer per clock and returns one result per transfer, in order.
// Registers in order form the magnitudes, the squares and their sum; the
// restoring divider stages then form c^2 * 2^(2F+2) / S one quotient bit at a
// time, the square-root stages form one root bit each, and the output register
// holds the rounded result.
// Results are rounded to nearest, ties away from zero. A stalled output holds
// the whole pipeline, and in_stall then follows it.
module vector3_normalize_direction
  import vnd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  vnd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output vnd_out_t out_data
);

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // front end
  logic signed [CW-1:0] a_c [NC];
  logic signed [CW-1:0] b_c [NC];
  assign a_c[0] = in_data.ax;
  assign a_c[1] = in_data.ay;
  assign a_c[2] = in_data.az;
  assign b_c[0] = in_data.bx;
  assign b_c[1] = in_data.by;
  assign b_c[2] = in_data.bz;

  logic          v1_r, v2_r, v3_r;
  logic [NC-1:0] neg1_r, neg2_r, neg3_r;
  logic [MW-1:0] mag1_r [NC];
  logic [QSW-1:0] sq2_r [NC];
  logic [QSW-1:0] sq3_r [NC];
  logic [SW-1:0]  sum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_front
    logic signed [MW-1:0] diff;
    logic [MW-1:0]        ndiff;
    assign diff  = (in_data.operation == OP_DIRECTION) ?
                   (MW'(b_c[k]) - MW'(a_c[k])) : MW'(a_c[k]);
    assign ndiff = MW'(-diff);
    always_ff @(posedge clk) begin
      if (en) begin
        neg1_r[k] <= diff[MW-1];
        mag1_r[k] <= diff[MW-1] ? ndiff : diff;
        neg2_r[k] <= neg1_r[k];
        sq2_r[k]  <= mag1_r[k] * mag1_r[k];
        neg3_r[k] <= neg2_r[k];
        sq3_r[k]  <= sq2_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r <= SW'(sq2_r[0]) + SW'(sq2_r[1]) + SW'(sq2_r[2]);
    end
  end

  // restoring divider, one quotient bit per stage
  logic          dv_r   [DSTEPS+1];
  logic          dz_r   [DSTEPS+1];
  logic [NC-1:0] dneg_r [DSTEPS+1];
  logic [SW-1:0] dsum_r [DSTEPS+1];
  logic [SW-1:0] drem_r [DSTEPS+1][NC];
  logic [QW-1:0] dquo_r [DSTEPS+1][NC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r[0]   <= (sum3_r == '0);
      dneg_r[0] <= neg3_r;
      dsum_r[0] <= sum3_r;
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_div0
    logic [SW-1:0] sqw;
    logic          ge;
    assign sqw = SW'(sq3_r[k]);
    assign ge  = sqw >= sum3_r;
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[0][k] <= ge ? (sqw - sum3_r) : sqw;
        dquo_r[0][k] <= QW'(ge);
      end
    end
  end

  for (genvar d = 1; d <= DSTEPS; d++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[d] <= 1'b0;
      end else if (en) begin
        dv_r[d] <= dv_r[d-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dz_r[d]   <= dz_r[d-1];
        dneg_r[d] <= dneg_r[d-1];
        dsum_r[d] <= dsum_r[d-1];
      end
    end
    for (genvar k = 0; k < NC; k++) begin : g_lane
      logic [SW:0] rx;
      logic [SW:0] dvs;
      logic [SW:0] df;
      logic        ge;
      assign rx  = {drem_r[d-1][k], 1'b0};
      assign dvs = {1'b0, dsum_r[d-1]};
      assign df  = rx - dvs;
      assign ge  = rx >= dvs;
      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[d][k] <= ge ? df[SW-1:0] : rx[SW-1:0];
          dquo_r[d][k] <= {dquo_r[d-1][k][QW-2:0], ge};
        end
      end
    end
  end

  // square root, one root bit per stage
  logic            sv_r   [RW];
  logic            sz_r   [RW];
  logic [NC-1:0]   sneg_r [RW];
  logic [2*RW-1:0] srad_r [RW][NC];
  logic [RW-1:0]   sroot_r[RW][NC];
  logic [RMW-1:0]  srem_r [RW][NC];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic          pv;
    logic          pz;
    logic [NC-1:0] pneg;
    if (j == 0) begin : g_first
      assign pv   = dv_r[DSTEPS];
      assign pz   = dz_r[DSTEPS];
      assign pneg = dneg_r[DSTEPS];
    end else begin : g_next
      assign pv   = sv_r[j-1];
      assign pz   = sz_r[j-1];
      assign pneg = sneg_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j] <= 1'b0;
      end else if (en) begin
        sv_r[j] <= pv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sz_r[j]   <= pz;
        sneg_r[j] <= pneg;
      end
    end
    for (genvar k = 0; k < NC; k++) begin : g_lane
      logic [2*RW-1:0] prad;
      logic [RW-1:0]   proot;
      logic [RMW-1:0]  prem;
      logic [RMW+1:0]  cand;
      logic [RMW+1:0]  trial;
      logic [RMW+1:0]  df;
      logic            ge;
      if (j == 0) begin : g_first
        assign prad  = (2*RW)'(dquo_r[DSTEPS][k]);
        assign proot = '0;
        assign prem  = '0;
      end else begin : g_next
        assign prad  = srad_r[j-1][k];
        assign proot = sroot_r[j-1][k];
        assign prem  = srem_r[j-1][k];
      end
      assign cand  = {prem, prad[2*RW-1 -: 2]};
      assign trial = (RMW+2)'({proot, 2'b01});
      assign df    = cand - trial;
      assign ge    = cand >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          srad_r[j][k]  <= {prad[2*RW-3:0], 2'b00};
          sroot_r[j][k] <= {proot[RW-2:0], ge};
          srem_r[j][k]  <= ge ? df[RMW-1:0] : cand[RMW-1:0];
        end
      end
    end
  end

  // round and sign
  logic [OW-1:0] res [NC];
  for (genvar k = 0; k < NC; k++) begin : g_out
    logic [RW:0]   rp1;
    logic [RW-1:0] n;
    assign rp1    = (RW+1)'(sroot_r[RW-1][k]) + (RW+1)'(1);
    assign n      = rp1[RW:1];
    assign res[k] = sz_r[RW-1] ? '0 : (sneg_r[RW-1][k] ? OW'(-n) : OW'(n));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.unit_x      <= res[0];
      out_data.unit_y      <= res[1];
      out_data.unit_z      <= res[2];
      out_data.zero_vector <= sz_r[RW-1];
    end
  end

endmodule

// ===== tb/sv/vector3_normalize_direction_test.sv =====
// Self-checking testbench for the pipelined vector normalizer and direction unit.
`timescale 1ns / 100ps

module vector3_normalize_direction_test;
  import vnd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int RANDOM_ITEMS   = 680;

  class unit_scoreboard;
    vnd_out_t pending_units[$];
    int mismatches;
    int results_seen;

    function automatic vnd_out_t unit_vector_of(vnd_in_t v);
      longint     comp [NC];
      logic [159:0] mag [NC];
      logic [159:0] sum_sq, rhs, lhs, odd;
      logic [31:0]  n, t;
      vnd_out_t     r;
      comp[0] = (v.operation == OP_DIRECTION) ? longint'(v.bx) - longint'(v.ax) : longint'(v.ax);
      comp[1] = (v.operation == OP_DIRECTION) ? longint'(v.by) - longint'(v.ay) : longint'(v.ay);
      comp[2] = (v.operation == OP_DIRECTION) ? longint'(v.bz) - longint'(v.az) : longint'(v.az);
      sum_sq = '0;
      for (int k = 0; k < NC; k++) begin
        mag[k] = (comp[k] < 0) ? 160'(-comp[k]) : 160'(comp[k]);
        sum_sq = sum_sq + mag[k] * mag[k];
      end
      r = '0;
      if (sum_sq == 0) begin
        r.zero_vector = 1'b1;
        return r;
      end
      for (int k = 0; k < NC; k++) begin
        n = '0;
        if (mag[k] != 0) begin
          rhs = (mag[k] * mag[k]) << (2 * FB + 2);
          for (int b = FB; b >= 0; b--) begin
            t = n | (32'd1 << b);
            odd = 160'(2 * t - 1);
            lhs = odd * odd * sum_sq;
            if (lhs <= rhs) n = t;
          end
        end
        if (comp[k] < 0) n = -n;
        case (k)
          0: r.unit_x = n;
          1: r.unit_y = n;
          default: r.unit_z = n;
        endcase
      end
      return r;
    endfunction

    function void note_input(vnd_in_t v);
      pending_units.push_back(unit_vector_of(v));
    endfunction

    function void check_result(vnd_out_t got);
      vnd_out_t want;
      results_seen++;
      if (pending_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_units.pop_front();
      if (got.unit_x !== want.unit_x || got.unit_y !== want.unit_y ||
          got.unit_z !== want.unit_z || got.zero_vector !== want.zero_vector) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%h y=%h z=%h zero=%b, got x=%h y=%h z=%h zero=%b",
                   want.unit_x, want.unit_y, want.unit_z, want.zero_vector,
                   got.unit_x, got.unit_y, got.unit_z, got.zero_vector);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  vnd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  vnd_out_t out_data;

  unit_scoreboard units = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_count = 0;
  int items_sent = 0;
  int directions_sent = 0;
  int zero_sent = 0;

  vector3_normalize_direction DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) units.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_count);
      $display("vector3_normalize_direction regression: fail");
      $finish;
    end
  end

  task automatic send_item(vnd_in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    units.note_input(v);
    items_sent++;
    if (v.operation == OP_DIRECTION) directions_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (units.pending_units.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_component(int style);
    case (style)
      0: return $urandom();
      1: return 32'($signed($urandom_range(511)) - 256);
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  function automatic vnd_in_t random_item();
    vnd_in_t v;
    int style;
    style = $urandom_range(9);
    v.operation = 1'($urandom_range(1));
    v.ax = random_component(style % 4);
    v.ay = random_component($urandom_range(3));
    v.az = random_component(style % 4);
    v.bx = random_component($urandom_range(3));
    v.by = random_component(style % 4);
    v.bz = random_component($urandom_range(3));
    case (style)
      7: begin
        v.by = v.ay;
        v.bz = v.az;
        if ($urandom_range(1) != 0) v.bx = v.ax;
      end
      8: begin
        v.ay = '0;
        v.az = '0;
        if ($urandom_range(1) != 0) v.ax = '0;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic vnd_in_t make_item(logic op, logic [31:0] ax, logic [31:0] ay,
                                        logic [31:0] az, logic [31:0] bx,
                                        logic [31:0] by, logic [31:0] bz);
    vnd_in_t v;
    v.operation = op;
    v.ax = ax; v.ay = ay; v.az = az;
    v.bx = bx; v.by = by; v.bz = bz;
    return v;
  endfunction

  initial begin
    vnd_in_t directed [$];
    vnd_in_t v;
    directed.push_back(make_item(OP_NORMALIZE, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_item(OP_NORMALIZE, 0, 0, 0, 32'hdead_beef, 5, 32'h8000_0000));
    directed.push_back(make_item(OP_DIRECTION, 7, -9, 32'h8000_0000, 7, -9, 32'h8000_0000));
    directed.push_back(make_item(OP_NORMALIZE, 32'h0001_0000, 0, 0, 0, 0, 0));
    directed.push_back(make_item(OP_NORMALIZE, 0, -1, 0, 0, 0, 0));
    directed.push_back(make_item(OP_NORMALIZE, 0, 0, 32'h8000_0000, 0, 0, 0));
    directed.push_back(make_item(OP_NORMALIZE, 0, 0, 32'h7fff_ffff, 0, 0, 0));
    directed.push_back(make_item(OP_DIRECTION, 0, 0, 0, 3, 0, 0));
    directed.push_back(make_item(OP_DIRECTION, 5, 0, 0, 5, 32'h7fff_ffff, 5));
    directed.push_back(make_item(OP_DIRECTION, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0));
    directed.push_back(make_item(OP_DIRECTION, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    directed.push_back(make_item(OP_DIRECTION, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(make_item(OP_NORMALIZE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 0, 0, 0));
    directed.push_back(make_item(OP_NORMALIZE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    directed.push_back(make_item(OP_NORMALIZE, 1, 1, 1, 0, 0, 0));
    directed.push_back(make_item(OP_NORMALIZE, -1, 1, -1, 0, 0, 0));
    directed.push_back(make_item(OP_NORMALIZE, 3, 4, 0, 0, 0, 0));
    directed.push_back(make_item(OP_NORMALIZE, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0));
    directed.push_back(make_item(OP_DIRECTION, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                 0, 0, 0));
    directed.push_back(make_item(OP_DIRECTION, 1, 2, 3, 1, 2, 4));
    directed.push_back(make_item(OP_DIRECTION, 32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f,
                                 32'hf0f0_f0f0, 32'h5555_5555, 32'haaaa_aaaa));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 27 : 0;
      if (phase == 0)
        foreach (directed[i]) send_item(directed[i]);
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        v = random_item();
        if (v.operation == OP_DIRECTION ? (v.ax == v.bx && v.ay == v.by && v.az == v.bz)
                                        : (v.ax == 0 && v.ay == 0 && v.az == 0))
          zero_sent++;
        send_item(v);
        if (phase == 1 && i == 100) begin
          go_idle();
          wait_drained();
        end
      end
    end
    go_idle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d vectors (%0d directions, %0d random zero cases), %0d results",
             items_sent, directions_sent, zero_sent, units.results_seen);
    $display("stall mixes: sender-heavy, receiver-heavy and none; mismatches %0d",
             units.mismatches);
    if (units.mismatches == 0 && units.pending_units.size() == 0)
      $display("vector3_normalize_direction regression: pass");
    else
      $display("vector3_normalize_direction regression: fail");
    $finish;
  end

endmodule
